### src/skl_pkg.sv
// Shared types and constants for the sorted key list.
package skl_pkg;

  localparam int SKL_DEPTH    = 16;
  localparam int SKL_KEY_BITS = 31;
  localparam int KEY_W        = 31;
  localparam int PAY_W        = 31;
  localparam int POS_W        = 4;
  localparam int COUNT_W      = 5;

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_DEL_FIRST = 2'd1;
  localparam logic [1:0] OP_DEL_LAST  = 2'd2;
  localparam logic [1:0] OP_DEL_AT    = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               head_valid;
    logic [KEY_W-1:0]   head_key;
    logic [PAY_W-1:0]   head_payload;
  } rsp_t;

  // Per-cell shift controls from the top level.
  typedef struct packed {
    logic ins;  // make room / take new entry
    logic del;  // take right neighbor (close gap)
  } cell_ctl_t;

endpackage

### src/skl_cell.sv
// One slot of the sorted row: holds an entry and shifts with its neighbors.
module skl_cell import skl_pkg::*; #(
  parameter int KEY_BITS = SKL_KEY_BITS
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic                occ,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [PAY_W-1:0]    new_pay,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [PAY_W-1:0]    left_pay,
  input  logic                left_flag,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [PAY_W-1:0]    right_pay,
  output logic [KEY_BITS-1:0] key,
  output logic [PAY_W-1:0]    pay,
  output logic                flag
);

  // Set from the insert point onward; equal keys stay ahead of the new one.
  assign flag = !occ || (key > new_key);

  always_ff @(posedge clk) begin
    if (ctl.ins && flag) begin
      if (left_flag) begin
        key <= left_key;
        pay <= left_pay;
      end else begin
        key <= new_key;
        pay <= new_pay;
      end
    end else if (ctl.del) begin
      key <= right_key;
      pay <= right_pay;
    end
  end

endmodule

### src/sorted_key_list.sv
// Sorted key list: up to DEPTH (key, payload) entries kept in ascending key order in a row of
// cells. Each cell compares its key with the incoming one in parallel; the row shifts right on
// insert, or left on delete first or at a position, as a whole. Delete last only lowers the
// count. One request is taken per clock; requests are held off only while a response waits
// behind a stalled output. Each response is registered from the state its request left. The
// count register resets to zero; the cell contents need no reset since only slots below the count are ever read.
module sorted_key_list import skl_pkg::*; #(
  parameter int DEPTH    = SKL_DEPTH,
  parameter int KEY_BITS = SKL_KEY_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]    count, count_next;
  logic [1:0]          status_q, status_next;
  logic                pend;
  logic                req_acc, rsp_load;
  logic                full, empty, pos_ok;
  logic                ins_en, del_en;
  logic [31:0]         del_base;
  logic [KEY_BITS-1:0] new_key;

  logic [KEY_BITS-1:0] cell_key  [DEPTH];
  logic [PAY_W-1:0]    cell_pay  [DEPTH];
  logic                cell_flag [DEPTH];
  cell_ctl_t           cell_ctl  [DEPTH];
  logic [DEPTH-1:0]    occ;

  assign rsp_load  = pend && (!rsp_valid || !rsp_stall);
  assign req_stall = pend && !rsp_load;
  assign req_acc   = req_valid && !req_stall;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pos_ok  = (32'(req.position) < 32'(count));
  assign new_key = KEY_BITS'({1'b0, req.key});
  assign ins_en  = (req.op == OP_INSERT) && !full;

  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    del_en      = 1'b0;
    del_base    = '0;
    case (req.op)
      OP_INSERT: begin
        if (full) status_next = ST_FULL;
        else      count_next  = count + 1'b1;
      end
      OP_DEL_FIRST: begin
        if (empty) begin
          status_next = ST_IGNORED;
        end else begin
          count_next = count - 1'b1;
          del_en     = 1'b1;
        end
      end
      OP_DEL_LAST: begin
        if (empty) status_next = ST_IGNORED;
        else       count_next  = count - 1'b1;
      end
      OP_DEL_AT: begin
        if (!pos_ok) begin
          status_next = ST_IGNORED;
        end else begin
          count_next = count - 1'b1;
          del_en     = 1'b1;
          del_base   = 32'(req.position);
        end
      end
      default: status_next = ST_DONE;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0] lkey, rkey;
    logic [PAY_W-1:0]    lpay, rpay;
    logic                lflag;

    assign occ[i]      = (CNT_W'(i) < count);
    assign cell_ctl[i] = '{ins: req_acc && ins_en,
                           del: req_acc && del_en && (32'(i) >= del_base)};

    if (i == 0) begin : g_first
      assign lkey  = '0;
      assign lpay  = '0;
      assign lflag = 1'b0;
    end else begin : g_mid
      assign lkey  = cell_key[i-1];
      assign lpay  = cell_pay[i-1];
      assign lflag = cell_flag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = cell_key[i];
      assign rpay = cell_pay[i];
    end else begin : g_inner
      assign rkey = cell_key[i+1];
      assign rpay = cell_pay[i+1];
    end

    skl_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .occ       (occ[i]),
      .new_key   (new_key),
      .new_pay   (req.payload),
      .left_key  (lkey),
      .left_pay  (lpay),
      .left_flag (lflag),
      .right_key (rkey),
      .right_pay (rpay),
      .key       (cell_key[i]),
      .pay       (cell_pay[i]),
      .flag      (cell_flag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        count    <= count_next;
        status_q <= status_next;
      end
      pend <= req_acc || (pend && !rsp_load);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      // built from the state left by the request it answers
      if (rsp_load) begin
        rsp.status      <= status_q;
        rsp.entry_count <= COUNT_W'(count);
        rsp.head_valid  <= !empty;
        if (empty) begin
          rsp.head_key     <= '0;
          rsp.head_payload <= '0;
        end else begin
          rsp.head_key     <= KEY_W'(32'(cell_key[0]));
          rsp.head_payload <= cell_pay[0];
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.op == OP_INSERT && !full) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow the count");

  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pend))
    else $error("response without a pending request");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> cell_key[0] <= cell_key[1])
    else $error("first two entries out of order");

endmodule

### tb/sv/tb_sorted_key_list.sv
// Self-checking testbench for the sorted key list: directed corner cases plus random traffic.
`timescale 1ns / 100ps

module tb_sorted_key_list;
  import skl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 185;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [PAY_W-1:0] PAY_MAX = {PAY_W{1'b1}};

  // Tracks the sorted contents and predicts the response of each request.
  class sorted_list_tracker;
    logic [KEY_W-1:0] keys [SKL_DEPTH];
    logic [PAY_W-1:0] pays [SKL_DEPTH];
    int unsigned held;
    rsp_t pending_rsps [$];
    int unsigned errors;
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen [3];
    int unsigned times_full;

    function void note_request(req_t r);
      logic [KEY_W-1:0] kmask;
      logic [KEY_W-1:0] k;
      int unsigned at;
      rsp_t exp;
      kmask = KEY_MAX >> (KEY_W - SKL_KEY_BITS);
      k = r.key & kmask;
      case (r.op)
        OP_INSERT: begin
          if (held >= SKL_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            at = 0;
            while (at < held && keys[at] <= k) at++;
            for (int i = held; i > at; i--) begin
              keys[i] = keys[i-1];
              pays[i] = pays[i-1];
            end
            keys[at] = k;
            pays[at] = r.payload;
            held++;
            if (held == SKL_DEPTH) times_full++;
            exp.status = ST_DONE;
          end
        end
        OP_DEL_FIRST, OP_DEL_AT: begin
          at = (r.op == OP_DEL_FIRST) ? 32'd0 : 32'(r.position);
          if (held == 0 || at >= held) begin
            exp.status = ST_IGNORED;
          end else begin
            for (int i = at; i + 1 < held; i++) begin
              keys[i] = keys[i+1];
              pays[i] = pays[i+1];
            end
            held--;
            exp.status = ST_DONE;
          end
        end
        default: begin
          if (held == 0) begin
            exp.status = ST_IGNORED;
          end else begin
            held--;
            exp.status = ST_DONE;
          end
        end
      endcase
      exp.entry_count = held[COUNT_W-1:0];
      exp.head_valid = (held != 0);
      exp.head_key = (held != 0) ? keys[0] : '0;
      exp.head_payload = (held != 0) ? pays[0] : '0;
      status_seen[exp.status]++;
      pending_rsps.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending_rsps.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected response status=%0d count=%0d head=%0d/%0d:%0d",
                   got.status, got.entry_count, got.head_valid, got.head_key,
                   got.head_payload);
        return;
      end
      exp = pending_rsps.pop_front();
      checked++;
      if (got.status !== exp.status || got.entry_count !== exp.entry_count ||
          got.head_valid !== exp.head_valid || got.head_key !== exp.head_key ||
          got.head_payload !== exp.head_payload) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: response %0d mismatch", checked);
          $display("  expected status=%0d count=%0d head=%0d key=%0d payload=%0d",
                   exp.status, exp.entry_count, exp.head_valid, exp.head_key,
                   exp.head_payload);
          $display("  actual   status=%0d count=%0d head=%0d key=%0d payload=%0d",
                   got.status, got.entry_count, got.head_valid, got.head_key,
                   got.head_payload);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  sorted_list_tracker sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned cycles;
  int unsigned sent;
  bit filling;

  sorted_key_list DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d responses outstanding", cycles,
               sb.pending_rsps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Receiver: random stalls, plus a long hold-off when the driver asks for one.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [KEY_W-1:0] key,
                                    logic [PAY_W-1:0] payload, logic [POS_W-1:0] position);
    req_t r;
    r.op = op;
    r.key = key;
    r.payload = payload;
    r.position = position;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 7));
      1: return KEY_W'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return KEY_MAX;
          default: return KEY_MAX - 1'b1;
        endcase
      end
      default: return KEY_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Random walk between filling and draining so both full and empty are hit often.
  function automatic req_t random_req();
    logic [1:0] op;
    logic [POS_W-1:0] position;
    logic [PAY_W-1:0] payload;
    if (filling && sb.held == SKL_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
    if (!filling && sb.held == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
      op = OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0: op = OP_DEL_FIRST;
        1: op = OP_DEL_LAST;
        default: op = OP_DEL_AT;
      endcase
    end
    if ($urandom_range(0, 9) < 7 && sb.held > 0)
      position = POS_W'($urandom_range(0, sb.held - 1));
    else
      position = POS_W'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: payload = '0;
      1: payload = PAY_MAX;
      default: payload = PAY_W'($urandom);
    endcase
    return make_req(op, pick_key(), payload, position);
  endfunction

  task automatic run_directed();
    // deletions on an empty list
    send_request(make_req(OP_DEL_FIRST, KEY_MAX, PAY_MAX, 4'd0));
    send_request(make_req(OP_DEL_LAST, '0, '0, 4'd15));
    send_request(make_req(OP_DEL_AT, '0, '0, 4'd0));
    // key and payload extremes, equal keys keep arrival order
    send_request(make_req(OP_INSERT, KEY_MAX, '0, 4'd0));
    send_request(make_req(OP_INSERT, '0, PAY_MAX, 4'd0));
    send_request(make_req(OP_INSERT, KEY_W'(5), PAY_W'(1), 4'd0));
    send_request(make_req(OP_INSERT, KEY_W'(5), PAY_W'(2), 4'd0));
    // index at count and far beyond it
    send_request(make_req(OP_DEL_AT, '0, '0, 4'd4));
    send_request(make_req(OP_DEL_AT, '0, '0, 4'd15));
    for (int i = 0; i < 12; i++)
      send_request(make_req(OP_INSERT, KEY_W'(i % 3 + 4), PAY_W'(100 + i), 4'd0));
    // full list: insert dropped, then remove from the far end and both ends
    send_request(make_req(OP_INSERT, '0, PAY_MAX, 4'd0));
    send_request(make_req(OP_DEL_AT, '0, '0, 4'd15));
    send_request(make_req(OP_DEL_LAST, '0, '0, 4'd0));
    send_request(make_req(OP_DEL_FIRST, '0, '0, 4'd0));
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    cycles = 0;
    sent = 0;
    filling = 1'b1;
    sb = new;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long output hold-off while requests keep coming, so the input backs up
        if (phase == 0 && n == 40) hold_requests++;
        send_request(random_req());
      end
    end
    req_valid <= 1'b0;

    while (sb.pending_rsps.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d requests, checked %0d responses; list reached full %0d times",
             sent, sb.checked, sb.times_full);
    $display("Statuses: %0d done, %0d dropped full, %0d ignored; %0d mismatches",
             sb.status_seen[ST_DONE], sb.status_seen[ST_FULL], sb.status_seen[ST_IGNORED],
             sb.mismatches);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
